// File: rtl/core/cctp_pkg.sv
// Shared types, character codes and helpers for the console color tag parser.
package cctp_pkg;

   localparam int CHAR_BITS  = 8;
   localparam int COLOR_BITS = 32;
   localparam int COORD_BITS = 16;

   // Default geometry of the parser
   localparam int TAG_DIGITS_DEF  = 6;
   localparam int GLYPH_WIDTH_DEF = 8;
   localparam int LINE_HEIGHT_DEF = 16;
   localparam int POS_BITS_DEF    = 16;

   localparam logic [CHAR_BITS-1:0] CHAR_OPEN    = 8'h7B;  // '{'
   localparam logic [CHAR_BITS-1:0] CHAR_CLOSE   = 8'h7D;  // '}'
   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;  // '\n'

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // What the window says about its head at this cycle
   typedef struct packed {
      logic empty;     // nothing pending
      logic must_pop;  // head goes out as plain text
      logic tag_ok;    // window holds a complete color tag
   } win_status_type;

   // Hex digit value, any other character counts as zero
   function automatic logic [3:0] nibble_of(input logic [CHAR_BITS-1:0] ch);
      logic [3:0] val;
      val = 4'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         val = 4'(ch - 8'h30);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         val = 4'(ch - 8'h37);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         val = 4'(ch - 8'h57);
      end
      return val;
   endfunction

endpackage

// File: rtl/core/cctp_window.sv
// Pending-character window: shift storage, tag match and tag color decode.
module cctp_window #(
   parameter int TAG_DIGITS = cctp_pkg::TAG_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [cctp_pkg::CHAR_BITS-1:0]   push_char,
   input  logic                             pop,
   input  logic                             clear,
   output logic [cctp_pkg::CHAR_BITS-1:0]   head_char,
   output cctp_pkg::win_status_type         status,
   output logic [cctp_pkg::COLOR_BITS-1:0]  tag_color
);
   import cctp_pkg::*;

   localparam int WIN_DEPTH = TAG_DIGITS + 2;
   localparam int FILL_BITS = $clog2(WIN_DEPTH + 1);
   localparam int IDX_BITS  = $clog2(WIN_DEPTH);

   logic [CHAR_BITS-1:0] chars_ff [WIN_DEPTH];
   logic [FILL_BITS-1:0] fill_ff;
   logic [FILL_BITS-1:0] fill_in;
   logic                 close_seen;
   logic                 full;
   logic                 head_open;

   // Fill count
   always_comb begin
      fill_in = fill_ff;
      if (clear) begin
         fill_in = '0;
      end else if (pop && fill_ff != '0) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end else if (push && fill_ff < FILL_BITS'(WIN_DEPTH)) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Character storage: append at the fill point, pop shifts toward the head
   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            chars_ff[i] <= chars_ff[i+1];
         end
      end else if (push && fill_ff < FILL_BITS'(WIN_DEPTH)) begin
         chars_ff[fill_ff[IDX_BITS-1:0]] <= push_char;
      end
   end

   // Tag checks on the pending characters
   always_comb begin
      close_seen = 1'b0;
      for (int i = 1; i <= TAG_DIGITS; i++) begin
         if (FILL_BITS'(i) < fill_ff && chars_ff[i] == CHAR_CLOSE) begin
            close_seen = 1'b1;
         end
      end
      full      = (fill_ff == FILL_BITS'(WIN_DEPTH));
      head_open = (chars_ff[0] == CHAR_OPEN);
      head_char = chars_ff[0];

      status.empty    = (fill_ff == '0);
      status.tag_ok   = head_open && !close_seen && full &&
                        (chars_ff[WIN_DEPTH-1] == CHAR_CLOSE);
      status.must_pop = !status.empty &&
                        (!head_open || close_seen || (full && !status.tag_ok));
   end

   // Digits read as nibbles, most significant first
   always_comb begin
      tag_color = '0;
      for (int i = 1; i <= TAG_DIGITS; i++) begin
         tag_color = {tag_color[COLOR_BITS-5:0], nibble_of(chars_ff[i])};
      end
   end

endmodule

// File: rtl/core/console_color_tag_parser_top.sv
// Top level of the console color tag parser: sequencer, cursor and result staging.
//
// Console color tag parser. Each request carries one character of a string;
// each result is one glyph placement (code, color, pixel column and row), with
// tlast marking the last result caused by a request. A '{', TAG_DIGITS
// characters other than '}', then '}' form a color tag that is dropped and sets
// the color; newlines move the cursor and give no result. A request enters the
// pending window, each character that leaves the window is placed in turn, a
// closing step ends the scan of the window, a flush places what is left on the
// last character of a string, and a final step hands over the last result. A
// new request is taken only when the previous one is through. The rate is set
// by the window sequencer, which handles one character per cycle through a
// single shared cursor adder, and by a full result register when the consumer
// stalls. Request tdata: char_code then start_color; tlast: last_char.
module console_color_tag_parser_top #(
   parameter int TAG_DIGITS  = cctp_pkg::TAG_DIGITS_DEF,
   parameter int GLYPH_WIDTH = cctp_pkg::GLYPH_WIDTH_DEF,
   parameter int LINE_HEIGHT = cctp_pkg::LINE_HEIGHT_DEF,
   parameter int POS_BITS    = cctp_pkg::POS_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [7:0] char_code, [39:8] start_color
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] glyph_code, [39:8] glyph_color,
                                    // [55:40] pos_x, [71:56] pos_y
   output logic        rsp_tlast    // run_end
);
   import cctp_pkg::*;

   state_type             state_ff, state_in;
   logic                  inside_ff, inside_in;
   logic                  last_ff, last_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [POS_BITS-1:0]   col_ff, col_in;
   logic [POS_BITS-1:0]   row_ff, row_in;

   // Held result: waits until it is known whether another follows
   logic                  held_valid_ff, held_valid_in;
   logic [CHAR_BITS-1:0]  held_code_ff, held_code_in;
   logic [COLOR_BITS-1:0] held_color_ff, held_color_in;
   logic [COORD_BITS-1:0] held_x_ff, held_x_in;
   logic [COORD_BITS-1:0] held_y_ff, held_y_in;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_load;
   logic                  out_last;
   logic [CHAR_BITS-1:0]  out_code_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_y_ff;
   logic                  out_last_ff;
   logic                  out_free;

   logic                  accept;
   logic                  win_pop;
   logic                  win_clear;
   logic [CHAR_BITS-1:0]  head_char;
   win_status_type        win_status;
   logic [COLOR_BITS-1:0] tag_color;

   logic                  place;
   logic                  place_nl;
   logic                  stall;
   logic [POS_BITS-1:0]   add_a, add_b, add_sum;

   cctp_window #(
      .TAG_DIGITS(TAG_DIGITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_char (req_tdata[7:0]),
      .pop       (win_pop),
      .clear     (win_clear),
      .head_char (head_char),
      .status    (win_status),
      .tag_color (tag_color)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // Shared cursor adder: column steps by a glyph, row steps by a line
   assign place_nl = (head_char == CHAR_NEWLINE);
   assign add_a    = place_nl ? row_ff : col_ff;
   assign add_b    = place_nl ? POS_BITS'(LINE_HEIGHT) : POS_BITS'(GLYPH_WIDTH);
   assign add_sum  = add_a + add_b;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      inside_in     = inside_ff;
      last_in       = last_ff;
      color_in      = color_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      held_valid_in = held_valid_ff;
      held_code_in  = held_code_ff;
      held_color_in = held_color_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      out_load      = 1'b0;
      out_last      = 1'b0;
      win_pop       = 1'b0;
      win_clear     = 1'b0;
      place         = 1'b0;
      stall         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!inside_ff) begin
                  color_in  = req_tdata[39:8];
                  inside_in = 1'b1;
               end
               last_in  = req_tlast;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (win_status.must_pop) begin
               place = 1'b1;
            end else begin
               if (win_status.tag_ok) begin
                  color_in  = tag_color;
                  win_clear = 1'b1;
               end
               state_in = last_ff ? ST_FLUSH : ST_FINISH;
            end
         end
         ST_FLUSH: begin
            if (!win_status.empty) begin
               place = 1'b1;
            end else begin
               inside_in = 1'b0;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (held_valid_ff) begin
               if (out_free) begin
                  out_load      = 1'b1;
                  out_last      = 1'b1;
                  held_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Place the head character: newline moves the cursor, others emit
      if (place) begin
         if (place_nl) begin
            col_in  = '0;
            row_in  = add_sum;
            win_pop = 1'b1;
         end else begin
            stall = held_valid_ff && !out_free;
            if (!stall) begin
               out_load      = held_valid_ff;
               held_valid_in = 1'b1;
               held_code_in  = head_char;
               held_color_in = color_ff;
               held_x_in     = COORD_BITS'(col_ff);
               held_y_in     = COORD_BITS'(row_ff);
               col_in        = add_sum;
               win_pop       = 1'b1;
            end
         end
      end

      // Output register occupancy
      out_valid_in = out_valid_ff && !rsp_tready;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inside_ff     <= 1'b0;
         last_ff       <= 1'b0;
         color_ff      <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inside_ff     <= inside_in;
         last_ff       <= last_in;
         color_ff      <= color_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      held_code_ff  <= held_code_in;
      held_color_ff <= held_color_in;
      held_x_ff     <= held_x_in;
      held_y_ff     <= held_y_in;
      if (out_load) begin
         out_code_ff  <= held_code_ff;
         out_color_ff <= held_color_ff;
         out_x_ff     <= held_x_ff;
         out_y_ff     <= held_y_ff;
         out_last_ff  <= out_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff, out_color_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// File: tb/tb_console_color_tag_parser_top.sv
// Testbench for the console color tag parser: directed and random strings checked against a predictor.
module tb_console_color_tag_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cctp_pkg::*;

   localparam int WIN_DEPTH      = TAG_DIGITS_DEF + 2;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic [CHAR_BITS-1:0]  code;
      logic [COLOR_BITS-1:0] color;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  run_end;
   } glyph_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // [7:0] char_code, [39:8] start_color
   logic        req_tlast  = 1'b0; // last_char
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // [7:0] glyph_code, [39:8] glyph_color,
                                   // [55:40] pos_x, [71:56] pos_y
   logic        rsp_tlast;         // run_end

   // Predictor state: pending window, color and cursor
   logic [CHAR_BITS-1:0]  win_chars [WIN_DEPTH];
   int                    win_fill     = 0;
   logic [COLOR_BITS-1:0] active_color = '0;
   logic [COORD_BITS-1:0] col_pos      = '0;
   logic [COORD_BITS-1:0] row_pos      = '0;
   logic                  in_string    = 1'b0;

   glyph_type fresh_glyphs[$];
   glyph_type expected_glyphs[$];
   int        errors      = 0;
   int        idle_cycles = 0;
   logic      no_idle     = 1'b0;

   console_color_tag_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Hex digit value of a tag character, zero for anything else
   function automatic logic [3:0] hex_value(input logic [CHAR_BITS-1:0] ch);
      if (ch >= 8'h30 && ch <= 8'h39) return ch[3:0];
      if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) return ch[3:0] + 4'd9;
      return 4'd0;
   endfunction

   // Take the window head out as plain text; newline only moves the cursor
   task automatic emit_head();
      logic [CHAR_BITS-1:0] ch;
      glyph_type            g;
      ch = win_chars[0];
      for (int i = 0; i < WIN_DEPTH - 1; i++) win_chars[i] = win_chars[i+1];
      win_fill--;
      if (ch == CHAR_NEWLINE) begin
         col_pos = '0;
         row_pos = row_pos + COORD_BITS'(LINE_HEIGHT_DEF);
      end else begin
         g.code    = ch;
         g.color   = active_color;
         g.x       = col_pos;
         g.y       = row_pos;
         g.run_end = 1'b0;
         fresh_glyphs.push_back(g);
         col_pos = col_pos + COORD_BITS'(GLYPH_WIDTH_DEF);
      end
   endtask

   // Glyphs caused by one accepted request
   task automatic predict_glyphs(input logic [CHAR_BITS-1:0] ch,
                                 input logic [COLOR_BITS-1:0] start,
                                 input logic last);
      logic                  tag_broken;
      int                    lim;
      logic [COLOR_BITS-1:0] tag_color;
      fresh_glyphs.delete();
      if (!in_string) begin
         active_color = start;
         in_string    = 1'b1;
      end
      if (win_fill < WIN_DEPTH) begin
         win_chars[win_fill] = ch;
         win_fill++;
      end
      while (win_fill > 0) begin
         if (win_chars[0] != CHAR_OPEN) begin
            emit_head();
            continue;
         end
         // a close brace among the digits kills the tag
         tag_broken = 1'b0;
         lim = (win_fill - 1 > TAG_DIGITS_DEF) ? TAG_DIGITS_DEF : win_fill - 1;
         for (int i = 1; i <= lim; i++) begin
            if (win_chars[i] == CHAR_CLOSE) tag_broken = 1'b1;
         end
         if (!tag_broken && win_fill == WIN_DEPTH) begin
            if (win_chars[WIN_DEPTH-1] == CHAR_CLOSE) begin
               tag_color = '0;
               for (int i = 1; i <= TAG_DIGITS_DEF; i++) begin
                  tag_color = {tag_color[COLOR_BITS-5:0], hex_value(win_chars[i])};
               end
               active_color = tag_color;
               win_fill     = 0;
               break;
            end
            tag_broken = 1'b1;
         end
         if (!tag_broken) break;
         emit_head();
      end
      // string end flushes whatever is still pending
      if (last) begin
         while (win_fill > 0) emit_head();
         in_string = 1'b0;
      end
      if (fresh_glyphs.size() > 0) fresh_glyphs[fresh_glyphs.size()-1].run_end = 1'b1;
      foreach (fresh_glyphs[i]) expected_glyphs.push_back(fresh_glyphs[i]);
   endtask

   // Send one character request, with random gaps ahead of it
   task automatic send_char(input logic [CHAR_BITS-1:0] ch,
                            input logic [COLOR_BITS-1:0] color,
                            input logic last);
      while (!no_idle && $urandom_range(99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {color, ch};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_glyphs(ch, color, last);
   endtask

   task automatic send_text(input string txt, input logic [COLOR_BITS-1:0] color);
      for (int i = 0; i < txt.len(); i++) send_char(txt[i], color, i == txt.len() - 1);
   endtask

   // Hold off the sender until every expected glyph has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_glyphs.size() != 0);
   endtask

   function automatic logic [CHAR_BITS-1:0] rand_digit();
      int idx;
      if ($urandom_range(1) == 0) begin
         idx = $urandom_range(21);
         if (idx < 10) return 8'h30 + idx[7:0];
         if (idx < 16) return 8'h41 + idx[7:0] - 8'd10;
         return 8'h61 + idx[7:0] - 8'd16;
      end
      do idx = $urandom_range(1, 255); while (idx[7:0] == CHAR_CLOSE);
      return idx[7:0];
   endfunction

   // Edge codes and colors, first character loads the color
   task automatic test_plain_glyphs();
      send_char(8'hFF, 32'hFFFF_FFFF, 1'b0);
      send_char(8'h00, 32'h0000_0000, 1'b0);
      send_char(8'h01, 32'h0000_0000, 1'b1);
   endtask

   // A hex tag with mixed case, then a glyph in the new color
   task automatic test_color_tags();
      send_text("{A1b2F0}Z", 32'h1234_5678);
   endtask

   // Nested open brace, early close, newline, and a flush at string end
   task automatic test_false_tag_flush();
      send_text("{{12}\n{3", 32'hDEAD_BEEF);
   endtask

   // Random characters and well-formed tags, with broken tags, braces and newlines mixed in
   task automatic test_random_strings(input int n_items);
      logic [CHAR_BITS-1:0] text[$];
      int sent;
      int tokens;
      int pick;
      int k;
      sent = 0;
      while (sent < n_items) begin
         text.delete();
         tokens = $urandom_range(1, 5);
         repeat (tokens) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
               text.push_back(CHAR_OPEN);
               repeat (TAG_DIGITS_DEF) text.push_back(rand_digit());
               text.push_back(CHAR_CLOSE);
            end else if (pick < 45) begin
               text.push_back(CHAR_OPEN);
               k = $urandom_range(0, TAG_DIGITS_DEF + 1);
               repeat (k) text.push_back(rand_digit());
               if ($urandom_range(1) == 1) text.push_back(CHAR_CLOSE);
            end else if (pick < 55) begin
               text.push_back(CHAR_NEWLINE);
            end else if (pick < 62) begin
               text.push_back($urandom_range(1) ? CHAR_OPEN : CHAR_CLOSE);
            end else begin
               text.push_back(8'($urandom_range(1, 255)));
            end
         end
         // an early stretch runs with no idling on either side
         no_idle = (sent < 60);
         foreach (text[i]) send_char(text[i], $urandom, i == text.size() - 1);
         sent += text.size();
      end
      no_idle = 1'b0;
   endtask

   // Result side: random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= no_idle || ($urandom_range(99) >= 34);
      end
   end

   // Compare each glyph with the oldest expectation
   always @(posedge clock) begin
      glyph_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_glyphs.size() == 0) begin
            $error("unexpected glyph: code %0h at (%0d,%0d)",
                   rsp_tdata[7:0], rsp_tdata[55:40], rsp_tdata[71:56]);
            errors++;
         end else begin
            want = expected_glyphs.pop_front();
            if (rsp_tdata[7:0] !== want.code) begin
               $error("glyph_code: expected %0h, got %0h", want.code, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[39:8] !== want.color) begin
               $error("glyph_color: expected %0h, got %0h", want.color, rsp_tdata[39:8]);
               errors++;
            end
            if (rsp_tdata[55:40] !== want.x) begin
               $error("pos_x: expected %0d, got %0d", want.x, rsp_tdata[55:40]);
               errors++;
            end
            if (rsp_tdata[71:56] !== want.y) begin
               $error("pos_y: expected %0d, got %0d", want.y, rsp_tdata[71:56]);
               errors++;
            end
            if (rsp_tlast !== want.run_end) begin
               $error("run_end: expected %0b, got %0b", want.run_end, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no request and no glyph accepted
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_glyphs();
      test_color_tags();
      test_false_tag_flush();
      wait_drained();
      test_random_strings(200);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_glyphs.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
